// File: src/sdf_pkg.sv
// ----------------------------------------------------------------------------
// sdf_pkg
// Shared types and constants of the signed decimal field formatter.
// ----------------------------------------------------------------------------
package sdf_pkg;

  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned MAX_DIGITS = 20;
  localparam int unsigned BCD_W      = MAX_DIGITS * DIGIT_W;
  localparam int unsigned DIDX_W     = $clog2(MAX_DIGITS);
  localparam int unsigned DCNT_W     = $clog2(MAX_DIGITS + 1);
  localparam int unsigned STEP_W     = $clog2(VALUE_W);
  localparam int unsigned QDEPTH     = 2;
  localparam int unsigned QPTR_W     = $clog2(QDEPTH);
  localparam int unsigned QCNT_W     = $clog2(QDEPTH + 1);

  localparam int unsigned APB_DW     = 32;
  localparam int unsigned APB_AW     = 5;

  localparam logic [LEN_W-1:0] MAX_FIELD = 7'd64;

  // register indexes
  localparam logic [2:0] REG_FIELD_WIDTH     = 3'd0;
  localparam logic [2:0] REG_PRECISION       = 3'd1;
  localparam logic [2:0] REG_PRECISION_GIVEN = 3'd2;
  localparam logic [2:0] REG_LEFT_JUSTIFY    = 3'd3;
  localparam logic [2:0] REG_ZERO_PAD        = 3'd4;
  localparam logic [2:0] REG_PLUS_FLAG       = 3'd5;
  localparam logic [2:0] REG_SPACE_FLAG      = 3'd6;

  localparam logic [CHAR_W-1:0] CH_NONE  = 8'h00;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;

  typedef struct packed {
    logic [6:0] field_width;
    logic [5:0] precision;
    logic       precision_given;
    logic       left_justify;
    logic       zero_pad;
    logic       plus_flag;
    logic       space_flag;
  } cfg_t;

  // one converted value waiting for the emitter
  typedef struct packed {
    logic [BCD_W-1:0]  digits;
    logic [DCNT_W-1:0] digit_count;
    logic [CHAR_W-1:0] sign_ch;
  } q_entry_t;

endpackage

// File: src/sdf_if.sv
// ----------------------------------------------------------------------------
// sdf_in_if / sdf_out_if
// Valid/ready stream channels of the formatter.
// ----------------------------------------------------------------------------
interface sdf_in_if;
  import sdf_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sdf_out_if;
  import sdf_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;
  logic              empty_res;
  logic [LEN_W-1:0]  total_length;
  modport source (output valid, output character, output last, output empty_res,
                  output total_length, input ready);
  modport sink   (input valid, input character, input last, input empty_res,
                  input total_length, output ready);
endinterface

// File: src/sdf_cfg.sv
// ----------------------------------------------------------------------------
// sdf_cfg
// APB register file holding the format configuration.
// ----------------------------------------------------------------------------
module sdf_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sdf_pkg::APB_AW-1:0]     paddr,
  input  logic [sdf_pkg::APB_DW-1:0]     pwdata,
  output logic [sdf_pkg::APB_DW-1:0]     prdata,
  output logic                           pready,
  output sdf_pkg::cfg_t                  cfg_o
);
  import sdf_pkg::*;

  cfg_t       cfg_q;
  logic [2:0] idx;
  logic       wr_en;

  assign idx   = paddr[4:2];
  assign wr_en = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_FIELD_WIDTH:     cfg_q.field_width     <= pwdata[6:0];
        REG_PRECISION:       cfg_q.precision       <= pwdata[5:0];
        REG_PRECISION_GIVEN: cfg_q.precision_given <= pwdata[0];
        REG_LEFT_JUSTIFY:    cfg_q.left_justify    <= pwdata[0];
        REG_ZERO_PAD:        cfg_q.zero_pad        <= pwdata[0];
        REG_PLUS_FLAG:       cfg_q.plus_flag       <= pwdata[0];
        REG_SPACE_FLAG:      cfg_q.space_flag      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FIELD_WIDTH:     prdata = {25'd0, cfg_q.field_width};
      REG_PRECISION:       prdata = {26'd0, cfg_q.precision};
      REG_PRECISION_GIVEN: prdata = {31'd0, cfg_q.precision_given};
      REG_LEFT_JUSTIFY:    prdata = {31'd0, cfg_q.left_justify};
      REG_ZERO_PAD:        prdata = {31'd0, cfg_q.zero_pad};
      REG_PLUS_FLAG:       prdata = {31'd0, cfg_q.plus_flag};
      REG_SPACE_FLAG:      prdata = {31'd0, cfg_q.space_flag};
      default:             prdata = '0;
    endcase
  end

endmodule

// File: src/sdf_front.sv
// ----------------------------------------------------------------------------
// sdf_front
// Accepts a value, picks its sign and converts the magnitude to decimal
// digits with a shift-add-3 converter, one bit per cycle.
// ----------------------------------------------------------------------------
module sdf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sdf_pkg::cfg_t     cfg_i,
  sdf_in_if.sink            in_i,
  output logic              push_o,
  input  logic              push_ready_i,
  output sdf_pkg::q_entry_t entry_o
);
  import sdf_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_CONV, F_SCAN, F_PUSH} fstate_e;

  fstate_e             state_q, state_d;
  logic [VALUE_W-1:0]  bin_q, bin_d;
  logic [BCD_W-1:0]    bcd_q, bcd_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [DIDX_W-1:0]   idx_q, idx_d;
  logic [DCNT_W-1:0]   dc_q, dc_d;
  logic [CHAR_W-1:0]   sign_q, sign_d;
  logic                skip_q, skip_d;

  logic [VALUE_W-1:0]  mag;
  logic [BCD_W-1:0]    adj;
  logic [DIGIT_W-1:0]  scan_digit;

  assign in_i.ready = (state_q == F_IDLE);
  assign mag = in_i.value[VALUE_W-1] ? (~in_i.value + 64'd1) : in_i.value;
  assign scan_digit = bcd_q[{idx_q, 2'b00} +: DIGIT_W];

  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd_q[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W] + 4'd3;
      end else begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  assign push_o = (state_q == F_PUSH);
  assign entry_o.digits      = bcd_q;
  assign entry_o.digit_count = skip_q ? '0 : dc_q;
  assign entry_o.sign_ch     = sign_q;

  always_comb begin
    state_d = state_q;
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    step_d  = step_q;
    idx_d   = idx_q;
    dc_d    = dc_q;
    sign_d  = sign_q;
    skip_d  = skip_q;
    case (state_q)
      F_IDLE: begin
        if (in_i.valid) begin
          bin_d  = mag;
          bcd_d  = '0;
          step_d = '0;
          skip_d = cfg_i.precision_given && (cfg_i.precision == 6'd0) && (mag == '0);
          if (in_i.value[VALUE_W-1]) begin
            sign_d = CH_MINUS;
          end else if (cfg_i.plus_flag) begin
            sign_d = CH_PLUS;
          end else if (cfg_i.space_flag) begin
            sign_d = CH_SPACE;
          end else begin
            sign_d = CH_NONE;
          end
          state_d = F_CONV;
        end
      end
      F_CONV: begin
        bcd_d  = {adj[BCD_W-2:0], bin_q[VALUE_W-1]};
        bin_d  = {bin_q[VALUE_W-2:0], 1'b0};
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(VALUE_W - 1)) begin
          idx_d   = DIDX_W'(MAX_DIGITS - 1);
          state_d = F_SCAN;
        end
      end
      F_SCAN: begin
        // walk down to the leading nonzero digit
        if ((scan_digit != '0) || (idx_q == '0)) begin
          dc_d    = DCNT_W'(idx_q) + 1'b1;
          state_d = F_PUSH;
        end else begin
          idx_d = idx_q - 1'b1;
        end
      end
      F_PUSH: begin
        if (push_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      bin_q   <= '0;
      bcd_q   <= '0;
      step_q  <= '0;
      idx_q   <= '0;
      dc_q    <= '0;
      sign_q  <= '0;
      skip_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      bin_q   <= bin_d;
      bcd_q   <= bcd_d;
      step_q  <= step_d;
      idx_q   <= idx_d;
      dc_q    <= dc_d;
      sign_q  <= sign_d;
      skip_q  <= skip_d;
    end
  end

endmodule

// File: src/sdf_queue.sv
// ----------------------------------------------------------------------------
// sdf_queue
// Short queue of converted values between converter and emitter.
// ----------------------------------------------------------------------------
module sdf_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              push_ready_o,
  input  sdf_pkg::q_entry_t entry_i,
  output logic              valid_o,
  input  logic              pop_i,
  output sdf_pkg::q_entry_t entry_o
);
  import sdf_pkg::*;

  q_entry_t          mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QDEPTH));
  assign valid_o      = (cnt_q != '0);
  assign entry_o      = mem_q[rd_ptr_q];
  assign do_push      = push_i & push_ready_o;
  assign do_pop       = pop_i & valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// File: src/sdf_back.sv
// ----------------------------------------------------------------------------
// sdf_back
// Lays out the field (padding, sign, leading zeros, digits) and emits it
// one character per cycle while not stalled, into a registered output.
// ----------------------------------------------------------------------------
module sdf_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sdf_pkg::cfg_t     cfg_i,
  input  logic              valid_i,
  input  sdf_pkg::q_entry_t entry_i,
  output logic              pop_o,
  sdf_out_if.source         out_o
);
  import sdf_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE, B_PRE, B_SIGN, B_ZERO, B_DIG, B_POST, B_EMPTY
  } bstate_e;

  bstate_e           state_q, state_d;
  logic [LEN_W-1:0]  cnt_q, cnt_d;
  logic [LEN_W-1:0]  zn_q, zn_d;
  logic [LEN_W-1:0]  post_q, post_d;
  logic [LEN_W-1:0]  total_q, total_d;
  logic [LEN_W-1:0]  pos_q, pos_d;
  logic              ovalid_q, ovalid_d;
  logic [CHAR_W-1:0] char_q, char_d;
  logic              last_q, last_d;
  logic              empty_q, empty_d;
  logic [LEN_W-1:0]  tlen_q, tlen_d;

  logic              can_emit, emit, is_last;
  logic [CHAR_W-1:0] emit_ch;
  logic              sign_len;
  logic [LEN_W-1:0]  dc7, zeros, body, width, pad, pre_n, zn_n, post_n, total_n;
  logic [DIDX_W-1:0] dig_idx;
  logic [DIGIT_W-1:0] digit;

  assign sign_len = (entry_i.sign_ch != CH_NONE);
  assign dc7      = LEN_W'(entry_i.digit_count);
  assign dig_idx  = cnt_q[DIDX_W-1:0] - 1'b1;
  assign digit    = entry_i.digits[{dig_idx, 2'b00} +: DIGIT_W];
  assign can_emit = !ovalid_q || out_o.ready;
  assign is_last  = (pos_q + 1'b1) == total_q;

  // field layout from the head entry and the configuration
  always_comb begin
    if (cfg_i.precision_given && (LEN_W'(cfg_i.precision) > dc7)) begin
      zeros = LEN_W'(cfg_i.precision) - dc7;
    end else begin
      zeros = '0;
    end
    body  = LEN_W'(sign_len) + zeros + dc7;
    width = (cfg_i.field_width > MAX_FIELD) ? MAX_FIELD : cfg_i.field_width;
    pad   = (width > body) ? width - body : '0;
    if (cfg_i.left_justify) begin
      pre_n  = '0;
      zn_n   = zeros;
      post_n = pad;
    end else if (cfg_i.zero_pad && !cfg_i.precision_given) begin
      pre_n  = '0;
      zn_n   = pad + zeros;
      post_n = '0;
    end else begin
      pre_n  = pad;
      zn_n   = zeros;
      post_n = '0;
    end
    total_n = pre_n + LEN_W'(sign_len) + zn_n + dc7 + post_n;
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    zn_d     = zn_q;
    post_d   = post_q;
    total_d  = total_q;
    pos_d    = pos_q;
    ovalid_d = ovalid_q && !out_o.ready;
    char_d   = char_q;
    last_d   = last_q;
    empty_d  = empty_q;
    tlen_d   = tlen_q;
    emit     = 1'b0;
    emit_ch  = CH_SPACE;
    pop_o    = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (valid_i) begin
          zn_d    = zn_n;
          post_d  = post_n;
          total_d = total_n;
          pos_d   = '0;
          cnt_d   = pre_n;
          state_d = (total_n == '0) ? B_EMPTY : B_PRE;
        end
      end
      B_PRE: begin
        if (cnt_q == '0) begin
          cnt_d   = LEN_W'(sign_len);
          state_d = B_SIGN;
        end else begin
          emit    = can_emit;
          emit_ch = CH_SPACE;
        end
      end
      B_SIGN: begin
        if (cnt_q == '0) begin
          cnt_d   = zn_q;
          state_d = B_ZERO;
        end else begin
          emit    = can_emit;
          emit_ch = entry_i.sign_ch;
        end
      end
      B_ZERO: begin
        if (cnt_q == '0) begin
          cnt_d   = dc7;
          state_d = B_DIG;
        end else begin
          emit    = can_emit;
          emit_ch = CH_ZERO;
        end
      end
      B_DIG: begin
        // most significant digit first
        if (cnt_q == '0) begin
          cnt_d   = post_q;
          state_d = B_POST;
        end else begin
          emit    = can_emit;
          emit_ch = CH_ZERO + CHAR_W'(digit);
        end
      end
      B_POST: begin
        if (cnt_q == '0) begin
          pop_o   = 1'b1;
          state_d = B_IDLE;
        end else begin
          emit    = can_emit;
          emit_ch = CH_SPACE;
        end
      end
      B_EMPTY: begin
        if (can_emit) begin
          ovalid_d = 1'b1;
          char_d   = CH_NONE;
          last_d   = 1'b1;
          empty_d  = 1'b1;
          tlen_d   = '0;
          pop_o    = 1'b1;
          state_d  = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
    if (emit) begin
      ovalid_d = 1'b1;
      char_d   = emit_ch;
      last_d   = is_last;
      empty_d  = 1'b0;
      tlen_d   = is_last ? total_q : '0;
      cnt_d    = cnt_q - 1'b1;
      pos_d    = pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      cnt_q    <= '0;
      zn_q     <= '0;
      post_q   <= '0;
      total_q  <= '0;
      pos_q    <= '0;
      ovalid_q <= 1'b0;
      char_q   <= '0;
      last_q   <= 1'b0;
      empty_q  <= 1'b0;
      tlen_q   <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      zn_q     <= zn_d;
      post_q   <= post_d;
      total_q  <= total_d;
      pos_q    <= pos_d;
      ovalid_q <= ovalid_d;
      char_q   <= char_d;
      last_q   <= last_d;
      empty_q  <= empty_d;
      tlen_q   <= tlen_d;
    end
  end

  assign out_o.valid        = ovalid_q;
  assign out_o.character    = char_q;
  assign out_o.last         = last_q;
  assign out_o.empty_res    = empty_q;
  assign out_o.total_length = tlen_q;

endmodule

// File: src/signed_decimal_field_formatter.sv
// ----------------------------------------------------------------------------
// signed_decimal_field_formatter
// Formats signed 64-bit values as printf %d text, one character per word.
//
// in_i carries one signed value per word; out_o returns the field's ASCII
// characters in order, last marking the final one, which also carries
// total_length. A field with no characters gives one word with empty_res
// set. Format settings are written over the APB port (field width,
// precision, precision given, left justify, zero pad, plus, space); the
// user must do so only while the block is idle, which it does not enforce.
// The front accepts a value, runs the bit-serial binary-to-decimal
// converter, scans for the leading digit and pushes the result into the
// queue. The back emits one character a cycle while the receiver is
// ready, and pauses for layout between the parts of a field. A two-entry
// queue lets a new value convert while the previous one is still emitted,
// so the sustained rate is set by the converter for short fields and by
// the character count for long ones.
// Reset clears the configuration to zero, empties the queue and drops any
// word in flight. A stalled receiver holds the output word; the emitter
// waits and the converter runs on until the queue is full.
// ----------------------------------------------------------------------------
module signed_decimal_field_formatter (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sdf_pkg::APB_AW-1:0] paddr,
  input  logic [sdf_pkg::APB_DW-1:0] pwdata,
  output logic [sdf_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  sdf_in_if.sink                     in_i,
  sdf_out_if.source                  out_o
);
  import sdf_pkg::*;

  cfg_t     cfg;
  q_entry_t push_entry, head_entry;
  logic     push, push_ready, head_valid, pop;

  sdf_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sdf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_i         (in_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .entry_o      (push_entry)
  );

  sdf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .entry_i      (push_entry),
    .valid_o      (head_valid),
    .pop_i        (pop),
    .entry_o      (head_entry)
  );

  sdf_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (head_valid),
    .entry_i (head_entry),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
